// File: hw/rtl/mktd_pkg.sv
// Shared types, constants and the letter lookup for the Morse key timing decoder.
// No dependencies; used by every module of the block.
package mktd_pkg;

    localparam int MAX_SYMBOLS = 9;
    localparam int CNT_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int TICK_W      = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_AW      = 3;
    localparam int CFG_NUM     = 8;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    localparam logic [CFG_AW-1:0] CFG_DOT_MIN    = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_DOT_MAX    = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_DASH_MIN   = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_DASH_MAX   = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_LETTER_GAP = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_WORD_GAP   = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_PHRASE_GAP = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_IDLE       = 3'd7;

    localparam logic [CFG_W-1:0] CFG_RESET [CFG_NUM] = '{
        16'd200, 16'd400, 16'd700, 16'd900, 16'd250, 16'd1490, 16'd3000, 16'd1000
    };

    localparam logic [1:0] KIND_LETTER = 2'd0;
    localparam logic [1:0] KIND_WORD   = 2'd1;
    localparam logic [1:0] KIND_PHRASE = 2'd2;

    localparam logic [6:0] CHAR_SPACE = 7'd32;
    localparam logic [6:0] CHAR_NONE  = 7'd0;
    localparam logic [6:0] CHAR_A     = 7'd65;

    localparam logic [2:0] MORSE_LEN [26] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
        3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
    };
    localparam logic [3:0] MORSE_BITS [26] = '{
        4'd2, 4'd1, 4'd5, 4'd1, 4'd0, 4'd4, 4'd3, 4'd0, 4'd0, 4'd14, 4'd5, 4'd2, 4'd3,
        4'd1, 4'd7, 4'd6, 4'd11, 4'd2, 4'd0, 4'd1, 4'd4, 4'd8, 4'd6, 4'd9, 4'd13, 4'd3
    };

    typedef struct packed {
        logic [6:0] char_code;
        logic       word;
        logic       phrase;
    } t_evt;

    typedef enum logic [2:0] {
        SUB_LETTER = 3'b001,
        SUB_WORD   = 3'b010,
        SUB_PHRASE = 3'b100
    } t_sub;

    function automatic logic [6:0] decode_store(input logic [CNT_W-1:0] cnt,
                                                input logic [MAX_SYMBOLS-1:0] bits);
        logic [6:0] res;
        res = CHAR_SPACE;
        for (int k = 0; k < 26; k++) begin
            if (cnt == CNT_W'(MORSE_LEN[k]) && bits == MAX_SYMBOLS'(MORSE_BITS[k])) begin
                res = CHAR_A + 7'(k);
            end
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/mktd_front.sv
// Front end: config registers, press/gap timing, symbol store and letter decode.
// Emits one event bundle per tick that has results. Depends on mktd_pkg.
module mktd_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mktd_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [mktd_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic                         i_key,
    input  logic                         i_full,
    output logic                         o_push,
    output mktd_pkg::t_evt               o_evt
);

    logic [mktd_pkg::CFG_W-1:0]       r_cfg [mktd_pkg::CFG_NUM];
    logic                             r_held, n_held;
    logic [mktd_pkg::TICK_W-1:0]      r_hticks, n_hticks;
    logic                             r_rel, n_rel;
    logic [mktd_pkg::TICK_W-1:0]      r_gap, n_gap;
    logic [mktd_pkg::MAX_SYMBOLS-1:0] r_bits, n_bits;
    logic [mktd_pkg::CNT_W-1:0]       r_cnt, n_cnt;
    logic                             accept;
    logic                             emit;

    assign o_ready = !i_full;
    assign accept  = i_valid && !i_full;

    always_comb begin
        logic [mktd_pkg::TICK_W-1:0] gap_inc;
        logic                        gap_hit;
        n_held   = r_held;
        n_hticks = r_hticks;
        n_rel    = r_rel;
        n_bits   = r_bits;
        n_cnt    = r_cnt;
        gap_inc  = (r_rel && r_gap != '1) ? r_gap + 1'b1 : r_gap;
        n_gap    = gap_inc;
        gap_hit  = 1'b0;
        emit     = 1'b0;
        o_evt    = '0;
        if (i_key && !r_held) begin
            n_held   = 1'b1;
            n_hticks = mktd_pkg::TICK_W'(1);
            gap_hit  = r_rel && (gap_inc > r_cfg[mktd_pkg::CFG_LETTER_GAP]);
        end else if (i_key) begin
            n_hticks = (r_hticks != '1) ? r_hticks + 1'b1 : r_hticks;
        end else if (r_held) begin
            if (r_cnt < mktd_pkg::CNT_W'(mktd_pkg::MAX_SYMBOLS)) begin
                if (r_hticks > r_cfg[mktd_pkg::CFG_DOT_MIN]
                        && r_hticks < r_cfg[mktd_pkg::CFG_DOT_MAX]) begin
                    n_cnt = r_cnt + 1'b1;
                end else if (r_hticks > r_cfg[mktd_pkg::CFG_DASH_MIN]
                        && r_hticks < r_cfg[mktd_pkg::CFG_DASH_MAX]) begin
                    n_bits = r_bits | (mktd_pkg::MAX_SYMBOLS'(1) << r_cnt);
                    n_cnt  = r_cnt + 1'b1;
                end
            end
            n_held   = 1'b0;
            n_hticks = '0;
            n_rel    = 1'b1;
            n_gap    = '0;
        end
        o_evt.char_code = mktd_pkg::decode_store(n_cnt, n_bits);
        if (gap_hit) begin
            emit         = 1'b1;
            o_evt.word   = gap_inc > r_cfg[mktd_pkg::CFG_WORD_GAP];
            o_evt.phrase = gap_inc > r_cfg[mktd_pkg::CFG_PHRASE_GAP];
        end else if (n_cnt != '0 && n_gap > r_cfg[mktd_pkg::CFG_IDLE]) begin
            emit = 1'b1;
        end
        if (emit) begin
            n_bits = '0;
            n_cnt  = '0;
        end
    end

    assign o_push = accept && emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg    <= mktd_pkg::CFG_RESET;
            r_held   <= 1'b0;
            r_hticks <= '0;
            r_rel    <= 1'b0;
            r_gap    <= '0;
            r_bits   <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_cfg_we) begin
                r_cfg[i_cfg_addr] <= i_cfg_data;
            end
            if (accept) begin
                r_held   <= n_held;
                r_hticks <= n_hticks;
                r_rel    <= n_rel;
                r_gap    <= n_gap;
                r_bits   <= n_bits;
                r_cnt    <= n_cnt;
            end
        end
    end

endmodule

// File: hw/rtl/mktd_queue.sv
// Short event-bundle FIFO between front and back ends.
// Register-based, depth from mktd_pkg::FIFO_DEPTH.
module mktd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mktd_pkg::t_evt i_din,
    input  logic           i_pop,
    output mktd_pkg::t_evt o_dout,
    output logic           o_full,
    output logic           o_empty
);

    mktd_pkg::t_evt                r_mem [mktd_pkg::FIFO_DEPTH];
    logic [mktd_pkg::FIFO_AW-1:0]  r_wp, r_rp;
    logic [mktd_pkg::FIFO_AW:0]    r_cnt;

    assign o_full  = (r_cnt == (mktd_pkg::FIFO_AW+1)'(mktd_pkg::FIFO_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_dout  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_din;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/mktd_back.sv
// Back end: expands each event bundle into letter, word-end and phrase-clear results.
// Drives the registered output stream. Depends on mktd_pkg.
module mktd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mktd_pkg::t_evt i_evt,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [1:0]     o_kind,
    output logic [6:0]     o_char,
    output logic           o_last
);

    logic               r_valid, n_valid;
    logic [1:0]         r_kind, n_kind;
    logic [6:0]         r_char, n_char;
    logic               r_last, n_last;
    mktd_pkg::t_sub     r_sub, n_sub;
    logic               load;

    assign load = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        n_kind  = r_kind;
        n_char  = r_char;
        n_last  = r_last;
        n_sub   = r_sub;
        o_pop   = 1'b0;
        if (load && !i_empty) begin
            n_valid = 1'b1;
            case (r_sub)
                mktd_pkg::SUB_LETTER: begin
                    n_kind = mktd_pkg::KIND_LETTER;
                    n_char = i_evt.char_code;
                    n_last = !i_evt.word && !i_evt.phrase;
                    n_sub  = i_evt.word   ? mktd_pkg::SUB_WORD :
                             i_evt.phrase ? mktd_pkg::SUB_PHRASE : mktd_pkg::SUB_LETTER;
                end
                mktd_pkg::SUB_WORD: begin
                    n_kind = mktd_pkg::KIND_WORD;
                    n_char = mktd_pkg::CHAR_NONE;
                    n_last = !i_evt.phrase;
                    n_sub  = i_evt.phrase ? mktd_pkg::SUB_PHRASE : mktd_pkg::SUB_LETTER;
                end
                default: begin
                    n_kind = mktd_pkg::KIND_PHRASE;
                    n_char = mktd_pkg::CHAR_NONE;
                    n_last = 1'b1;
                    n_sub  = mktd_pkg::SUB_LETTER;
                end
            endcase
            o_pop = n_last;
        end else if (load) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sub   <= mktd_pkg::SUB_LETTER;
        end else begin
            r_valid <= n_valid;
            r_sub   <= n_sub;
        end
        r_kind <= n_kind;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign o_valid = r_valid;
    assign o_kind  = r_kind;
    assign o_char  = r_char;
    assign o_last  = r_last;

endmodule

// File: hw/rtl/morse_key_timing_decoder.sv
// Morse key timing decoder, top level: front end, event FIFO, back end.
// The first result of a tick passes the event FIFO and then the output register.
// Throughput: one tick per cycle while the 4-entry FIFO has room; a tick with more
// than one result holds the output until all are taken; m_axis sets the sustained rate.
// Reset (synchronous, active low) clears timing state, store, FIFO and output and
// loads default thresholds; no clearing pass. Depends on mktd_pkg and submodules.
module morse_key_timing_decoder (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [mktd_pkg::CFG_AW-1:0]  i_cfg_addr,
    input  logic [mktd_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [7:0]                   s_axis_tdata,   // [0] key_level, [7:1] zero
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [15:0]                  m_axis_tdata,   // [1:0] event_kind, [8:2] char_code
    output logic                         m_axis_tlast
);

    mktd_pkg::t_evt push_evt, head_evt;
    logic           push, pop, full, empty;
    logic [1:0]     kind;
    logic [6:0]     char_code;

    mktd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_key      (s_axis_tdata[0]),
        .i_full     (full),
        .o_push     (push),
        .o_evt      (push_evt)
    );

    mktd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_din   (push_evt),
        .i_pop   (pop),
        .o_dout  (head_evt),
        .o_full  (full),
        .o_empty (empty)
    );

    mktd_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_evt   (head_evt),
        .i_empty (empty),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_kind  (kind),
        .o_char  (char_code),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {7'd0, char_code, kind};

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> !full)
        else $error("event FIFO overflow");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (kind != 2'd3))
        else $error("invalid event kind");

    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && kind != mktd_pkg::KIND_LETTER) |-> (char_code == mktd_pkg::CHAR_NONE))
        else $error("non-letter result carries a character");

    a_follow_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
            |=> (m_axis_tvalid && kind != mktd_pkg::KIND_LETTER))
        else $error("bundle continuation missing or starts a new letter");
`endif

endmodule
